@@ hw/rtl/ecal_pkg.sv @@
// ----------------------------------------------------------------------------
// ecal_pkg: shared types and constants for the epoch-to-calendar converter
// Holds field widths, pipeline depth, the reciprocal constants used for
// division by constants, and the small month-start table.
// ----------------------------------------------------------------------------
package ecal_pkg;

  // Pipeline depth in register stages, input register through output register.
  localparam int unsigned LAT = 11;
  // Stages 1..3 belong to the seconds splitter; the rest follow it.
  localparam int unsigned SPLIT_STAGES = 3;
  localparam int unsigned TAIL_STAGES  = LAT - SPLIT_STAGES;

  localparam logic [37:0] LAST_SECOND = 38'd253402300799;

  // Divisors. 86400 is 675 shifted left by 7.
  localparam longint unsigned DayOdd     = 675;
  localparam longint unsigned DaysPerEra = 146097;
  localparam longint unsigned DaysToEpoch = 719468;
  localparam longint unsigned Days4Yr    = 1460;
  localparam longint unsigned Days100Yr  = 36524;
  localparam longint unsigned DaysYr     = 365;

  // Reciprocals: ceil(2^k / d), exact for the operand widths in use.
  localparam logic [31:0] M_DAY  = 32'(((64'd1 << 41) + DayOdd - 1) / DayOdd);
  localparam logic [22:0] M_WK   = 23'(((64'd1 << 25) + 64'd6) / 64'd7);
  localparam logic [15:0] M_MIN  = 16'(((64'd1 << 19) + 64'd14) / 64'd15);
  localparam logic [9:0]  M_HR   = 10'(((64'd1 << 13) + 64'd14) / 64'd15);
  localparam logic [22:0] M_ERA  = 23'(((64'd1 << 40) + DaysPerEra - 1) / DaysPerEra);
  localparam logic [18:0] M_Q4   = 19'(((64'd1 << 29) + Days4Yr - 1) / Days4Yr);
  localparam logic [18:0] M_YR   = 19'(((64'd1 << 27) + DaysYr - 1) / DaysYr);
  localparam logic [9:0]  M_CENT = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] M_MP   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // Time of day and weekday of one item.
  typedef struct packed {
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } ecal_tod_t;

  // Calendar date of one item.
  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } ecal_date_t;

  // Day of a March-based year on which month index mp starts.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    unique case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/ecal_split.sv @@
// ----------------------------------------------------------------------------
// ecal_split: seconds count to day count and second of day
// Three stages: input register, reciprocal multiply by 1/675 on the count
// shifted right by 7, then the day count and the remainder within the day.
// ----------------------------------------------------------------------------
module ecal_split (
  input  logic                                   clk,
  input  logic [ecal_pkg::SPLIT_STAGES-1:0]      en,
  input  logic [37:0]                            epoch_seconds,
  output logic [21:0]                            days,
  output logic [16:0]                            sec_of_day,
  output logic                                   oor
);
  import ecal_pkg::*;

  logic [37:0] secs1;
  logic        oor1;
  logic [62:0] prod2;
  logic [30:0] q2;
  logic [6:0]  lo2;
  logic        oor2;
  logic [21:0] days_c;
  logic [9:0]  rq_c;

  // Stage 1: capture the item and flag counts beyond year 9999.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      secs1 <= epoch_seconds;
      oor1  <= epoch_seconds > LAST_SECOND;
    end
  end

  // Stage 2: multiply by the reciprocal of 675.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod2 <= 63'(secs1[37:7]) * 63'(M_DAY);
      q2    <= secs1[37:7];
      lo2   <= secs1[6:0];
      oor2  <= oor1;
    end
  end

  // Stage 3: day count, and the remainder rebuilt from the low bits.
  always_comb begin
    days_c = prod2[62:41];
    rq_c   = 10'(q2 - 31'(days_c) * 31'(DayOdd));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      days       <= days_c;
      sec_of_day <= {rq_c, lo2};
      oor        <= oor2;
    end
  end

endmodule

@@ hw/rtl/ecal_clock.sv @@
// ----------------------------------------------------------------------------
// ecal_clock: weekday and time of day
// Hour, minute and second come from the second of day through two
// reciprocal multiplies by 1/15; the weekday from the day count modulo 7.
// A short delay line aligns the result with the date path.
// ----------------------------------------------------------------------------
module ecal_clock (
  input  logic                               clk,
  input  logic [ecal_pkg::TAIL_STAGES-1:0]   en,
  input  logic [21:0]                        days,
  input  logic [16:0]                        sec_of_day,
  output ecal_pkg::ecal_tod_t                tod
);
  import ecal_pkg::*;

  localparam int unsigned DLY = TAIL_STAGES - 3;

  logic [21:0] dp4_c;
  logic [21:0] dp4_r;
  logic [44:0] wprod4;
  logic [30:0] mprod4;
  logic [16:0] rem4;
  logic [19:0] q7_c;
  logic [10:0] mins_c;
  logic [2:0]  wk5;
  logic [5:0]  sec5;
  logic [10:0] mins5;
  logic [18:0] hprod5;
  logic [4:0]  hr_c;
  ecal_tod_t   tod6;
  ecal_tod_t   dly [DLY];

  // Stage 4: reciprocal products for the weekday and the minute count.
  assign dp4_c = days + 22'd4;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dp4_r  <= dp4_c;
      wprod4 <= 45'(dp4_c) * 45'(M_WK);
      mprod4 <= 31'(sec_of_day[16:2]) * 31'(M_MIN);
      rem4   <= sec_of_day;
    end
  end

  // Stage 5: weekday, minute of day and second; start the hour divide.
  always_comb begin
    q7_c   = 20'(wprod4 >> 25);
    mins_c = 11'(mprod4 >> 19);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      wk5    <= 3'(dp4_r - 22'(q7_c) * 22'd7);
      sec5   <= 6'(rem4 - 17'(mins_c) * 17'd60);
      mins5  <= mins_c;
      hprod5 <= 19'(mins_c[10:2]) * 19'(M_HR);
    end
  end

  // Stage 6: hour and minute of hour.
  assign hr_c = 5'(hprod5 >> 13);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tod6.weekday <= wk5;
      tod6.hour    <= hr_c;
      tod6.minute  <= 6'(mins5 - 11'(hr_c) * 11'd60);
      tod6.second  <= sec5;
    end
  end

  // Delay line up to the output stage.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DLY; i++) begin
      if (en[3 + i]) begin
        dly[i] <= (i == 0) ? tod6 : dly[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign tod = dly[DLY-1];

endmodule

@@ hw/rtl/ecal_civil.sv @@
// ----------------------------------------------------------------------------
// ecal_civil: day count to year, month and day of month
// Closed-form conversion over 400-year eras counted from 0000-03-01, at most one
// reciprocal multiply per stage, eight stages in all.
// ----------------------------------------------------------------------------
module ecal_civil (
  input  logic                               clk,
  input  logic [ecal_pkg::TAIL_STAGES-1:0]   en,
  input  logic [21:0]                        days,
  output ecal_pkg::ecal_date_t               date
);
  import ecal_pkg::*;

  logic [21:0] z_c;
  logic [21:0] z4;
  logic [44:0] eprod4;
  logic [4:0]  era_c;
  logic [4:0]  era5, era6, era7, era8, era9, era10;
  logic [17:0] doe5, doe6, doe7, doe8;
  logic [36:0] aprod6;
  logic [2:0]  b6;
  logic        c6;
  logic [6:0]  a_c;
  logic [17:0] t_c;
  logic [36:0] yprod7;
  logic [8:0]  yoe_c;
  logic [8:0]  yoe8, yoe9, yoe10;
  logic [18:0] cprod8;
  logic [1:0]  c100_c;
  logic [8:0]  doy9, doy10;
  logic [10:0] x_c;
  logic [22:0] mprod10;
  logic [3:0]  mp_c;
  logic [3:0]  m_c;

  // Stage 4: shift the origin to 0000-03-01 and divide by the era length.
  assign z_c = 22'(days + 22'(DaysToEpoch));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      z4     <= z_c;
      eprod4 <= 45'(z_c) * 45'(M_ERA);
    end
  end

  // Stage 5: era and day of era.
  assign era_c = 5'(eprod4 >> 40);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      era5 <= era_c;
      doe5 <= 18'(z4 - 22'(era_c) * 22'(DaysPerEra));
    end
  end

  // Stage 6: leap-day corrections within the era.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      era6   <= era5;
      doe6   <= doe5;
      aprod6 <= 37'(doe5) * 37'(M_Q4);
      b6     <= 3'(doe5 >= 18'(Days100Yr)) + 3'(doe5 >= 18'(2 * Days100Yr))
              + 3'(doe5 >= 18'(3 * Days100Yr)) + 3'(doe5 >= 18'(4 * Days100Yr));
      c6     <= doe5 == 18'(DaysPerEra - 1);
    end
  end

  // Stage 7: corrected day count, divided by the year length.
  always_comb begin
    a_c = 7'(aprod6 >> 29);
    t_c = doe6 - 18'(a_c) + 18'(b6) - 18'(c6);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      era7   <= era6;
      doe7   <= doe6;
      yprod7 <= 37'(t_c) * 37'(M_YR);
    end
  end

  // Stage 8: year of era, and its century count.
  assign yoe_c = 9'(yprod7 >> 27);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      era8   <= era7;
      doe8   <= doe7;
      yoe8   <= yoe_c;
      cprod8 <= 19'(yoe_c) * 19'(M_CENT);
    end
  end

  // Stage 9: day of the March-based year.
  assign c100_c = 2'(cprod8 >> 16);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      era9 <= era8;
      yoe9 <= yoe8;
      doy9 <= 9'(doe8 - (18'(yoe8) * 18'(DaysYr) + 18'(yoe8[8:2]) - 18'(c100_c)));
    end
  end

  // Stage 10: month index by multiplying by the reciprocal of 153.
  assign x_c = 11'(doy9) * 11'd5 + 11'd2;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      era10   <= era9;
      yoe10   <= yoe9;
      doy10   <= doy9;
      mprod10 <= 23'(x_c) * 23'(M_MP);
    end
  end

  // Stage 11: month, day and year; January and February belong to the next year.
  always_comb begin
    mp_c = 4'(mprod10 >> 19);
    m_c  = (mp_c < 4'd10) ? 4'(mp_c + 4'd3) : 4'(mp_c - 4'd9);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      date.month <= m_c;
      date.day   <= 5'(doy10 - month_start(mp_c) + 9'd1);
      date.year  <= 14'(yoe10) + 14'(era10) * 14'd400 + 14'(m_c <= 4'd2);
    end
  end

endmodule

@@ hw/rtl/epoch_seconds_to_calendar.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to UTC weekday, date and time
//
//  Channel | Direction | Bits   | Contents
//  s_*     | in        | 40     | tdata: epoch_seconds
//  m_*     | out       | 48 + 1 | tdata: weekday, year, month, day, hour, minute, second
//          |           |        | tuser: out_of_range flag
//
// One item enters per cycle unless a stall holds it; each result passes through
// the 11 register stages of the whole path.
// Each stage has a valid bit and loads when it is empty or its successor
// moves, so bubbles close up and a stall on m_tready holds every item.
// Reset clears the valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [37:0] epoch_seconds
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] weekday, [16:3] year, [20:17] month, [25:21] day_of_month,
  // [30:26] hour, [36:31] minute, [42:37] second
  output logic [47:0] m_tdata,
  // [0] out_of_range
  output logic        m_tuser
);
  import ecal_pkg::*;

  logic [LAT:1] v;
  logic [LAT:1] en;
  logic [21:0]  days;
  logic [16:0]  sec_of_day;
  logic         oor3;
  logic         oor_d [LAT-SPLIT_STAGES];
  logic         oor_out;
  ecal_tod_t    tod;
  ecal_date_t   date;

  // Stage enables ripple back from the output.
  always_comb begin
    en[LAT] = !v[LAT] || m_tready;
    for (int i = LAT - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[LAT];

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= LAT; i++) begin
        if (en[i]) begin
          v[i] <= (i == 1) ? s_tvalid : v[(i == 1) ? 1 : i - 1];
        end
      end
    end
  end

  // Out-of-range flag follows the tail stages.
  always_ff @(posedge clk) begin
    for (int i = 0; i < LAT - SPLIT_STAGES; i++) begin
      if (en[SPLIT_STAGES + 1 + i]) begin
        oor_d[i] <= (i == 0) ? oor3 : oor_d[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign oor_out = oor_d[LAT-SPLIT_STAGES-1];

  ecal_split u_split (
    .clk           (clk),
    .en            (en[SPLIT_STAGES:1]),
    .epoch_seconds (s_tdata[37:0]),
    .days          (days),
    .sec_of_day    (sec_of_day),
    .oor           (oor3)
  );

  ecal_clock u_clock (
    .clk        (clk),
    .en         (en[LAT:SPLIT_STAGES+1]),
    .days       (days),
    .sec_of_day (sec_of_day),
    .tod        (tod)
  );

  ecal_civil u_civil (
    .clk  (clk),
    .en   (en[LAT:SPLIT_STAGES+1]),
    .days (days),
    .date (date)
  );

  // Out-of-range items carry only the flag.
  assign m_tdata = oor_out ? 48'd0
                           : {5'd0, tod.second, tod.minute, tod.hour,
                              date.day, date.month, date.year, tod.weekday};
  assign m_tuser = oor_out;

  // A valid date has a real month and day.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !oor_out |-> date.month >= 4'd1 && date.month <= 4'd12
                             && date.day >= 5'd1)
    else $error("month or day of month out of range");

  // Time of day and weekday stay within their counts.
  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !oor_out |-> tod.hour < 5'd24 && tod.minute < 6'd60
                             && tod.second < 6'd60 && tod.weekday < 3'd7)
    else $error("time of day or weekday out of range");

  // Years in range start at the epoch and end at 9999.
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !oor_out |-> date.year >= 14'd1970 && date.year <= 14'd9999)
    else $error("year out of range");

endmodule
